// File: sv/fgn_pkg.sv
// fgn_pkg: shared constants, types and table functions for the fractal noise pixel block.
// Used by fgn_octave_cell, fgn_level_map and fractal_gradient_noise_pixel.
// No dependencies.
`default_nettype none

package fgn_pkg;

    localparam logic [31:0] HASH_MUL_A  = 32'd3284157443;
    localparam logic [31:0] HASH_MUL_B  = 32'd1911520717;
    localparam logic [31:0] HASH_MUL_C  = 32'd2048419325;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    localparam int DOT_W   = 21;
    localparam int NOISE_W = 22;

    localparam logic REG_OCTAVE_COUNT = 1'b0;
    localparam logic REG_CELL_SHIFT   = 1'b1;

    typedef enum logic [1:0] {
        Q_ZERO  = 2'd0,
        Q_ONE   = 2'd1,
        Q_TWO   = 2'd2,
        Q_THREE = 2'd3
    } quarter_t;

    function automatic logic [31:0] rot16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    // Q1.14 cos or sin of a quarter-turn angle, series in Q30; elaboration only.
    function automatic logic [14:0] grad_q14(input int unsigned r, input int unsigned qs,
                                             input logic want_sin);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] tc;
        logic [63:0] ts;
        longint      c;
        longint      s;
        longint      v;
        t  = (64'(r) * PI_HALF_Q30) >> qs;
        t2 = (t * t) >> 30;
        tc = 64'd1 << 30;
        ts = t;
        c  = longint'(tc);
        s  = longint'(ts);
        tc = ((tc * t2) >> 30) / 2;
        ts = ((ts * t2) >> 30) / 6;
        c  = c - longint'(tc);
        s  = s - longint'(ts);
        tc = ((tc * t2) >> 30) / 12;
        ts = ((ts * t2) >> 30) / 20;
        c  = c + longint'(tc);
        s  = s + longint'(ts);
        tc = ((tc * t2) >> 30) / 30;
        ts = ((ts * t2) >> 30) / 42;
        c  = c - longint'(tc);
        s  = s - longint'(ts);
        tc = ((tc * t2) >> 30) / 56;
        ts = ((ts * t2) >> 30) / 72;
        c  = c + longint'(tc);
        s  = s + longint'(ts);
        tc = ((tc * t2) >> 30) / 90;
        ts = ((ts * t2) >> 30) / 110;
        c  = c - longint'(tc);
        s  = s - longint'(ts);
        tc = ((tc * t2) >> 30) / 132;
        ts = ((ts * t2) >> 30) / 156;
        c  = c + longint'(tc);
        s  = s + longint'(ts);
        v  = want_sin ? s : c;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > (longint'(1) << 30))
        begin
            v = longint'(1) << 30;
        end
        return 15'((v + (longint'(1) << 15)) >>> 16);
    endfunction

endpackage

`default_nettype wire

// File: sv/fractal_gradient_noise_pixel.sv
// fractal_gradient_noise_pixel: top level, config registers, chain of octave cells, level map.
// Depends on fgn_pkg, fgn_octave_cell, fgn_level_map.
// Pipeline: one cell of 12 stages per octave, then the level map.
// Throughput: one pixel per cycle; busy stays low and done cannot be stalled.
// Reset: octave_count returns to 4, cell_shift to 6, pipeline emptied.
`default_nettype none

module fractal_gradient_noise_pixel
    import fgn_pkg::*;
#(
    parameter int MAX_OCTAVES      = 8,
    parameter int ANGLE_TABLE_BITS = 10,
    parameter int FRAC_BITS        = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] pixel_x,
    input  logic [15:0] pixel_y,
    output logic        done,
    output logic [7:0]  noise_level,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int ACC_W = NOISE_W + MAX_OCTAVES;

    logic [3:0] octave_count_reg;
    logic [3:0] cell_shift_reg;

    logic                    chain_valid [MAX_OCTAVES+1];
    logic [15:0]             chain_x     [MAX_OCTAVES+1];
    logic [15:0]             chain_y     [MAX_OCTAVES+1];
    logic signed [ACC_W-1:0] chain_acc   [MAX_OCTAVES+1];

    assign busy           = 1'b0;
    assign chain_valid[0] = start;
    assign chain_x[0]     = pixel_x;
    assign chain_y[0]     = pixel_y;
    assign chain_acc[0]   = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= 4'd4;
            cell_shift_reg   <= 4'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OCTAVE_COUNT: octave_count_reg <= cfg_data;
                REG_CELL_SHIFT:   cell_shift_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    for (genvar o = 0; o < MAX_OCTAVES; o++)
    begin : g_cell
        fgn_octave_cell #(
            .MAX_OCTAVES      (MAX_OCTAVES),
            .ANGLE_TABLE_BITS (ANGLE_TABLE_BITS),
            .FRAC_BITS        (FRAC_BITS),
            .OCT              (o)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .in_valid     (chain_valid[o]),
            .in_x         (chain_x[o]),
            .in_y         (chain_y[o]),
            .in_acc       (chain_acc[o]),
            .octave_count (octave_count_reg),
            .cell_shift   (cell_shift_reg),
            .out_valid    (chain_valid[o+1]),
            .out_x        (chain_x[o+1]),
            .out_y        (chain_y[o+1]),
            .out_acc      (chain_acc[o+1])
        );
    end

    fgn_level_map #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (chain_valid[MAX_OCTAVES]),
        .in_acc      (chain_acc[MAX_OCTAVES]),
        .done        (done),
        .noise_level (noise_level)
    );

endmodule

`default_nettype wire

// File: sv/fgn_octave_cell.sv
// fgn_octave_cell: one octave of gradient noise, pipelined, adding into the running sum.
// Passes pixel, sum and valid on to the next cell through a registered delay line.
// Depends on fgn_pkg.
`default_nettype none

module fgn_octave_cell
    import fgn_pkg::*;
#(
    parameter int MAX_OCTAVES      = 8,
    parameter int ANGLE_TABLE_BITS = 10,
    parameter int FRAC_BITS        = 16,
    parameter int OCT              = 0,
    localparam int ACC_W           = NOISE_W + MAX_OCTAVES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [15:0]             in_x,
    input  logic [15:0]             in_y,
    input  logic signed [ACC_W-1:0] in_acc,
    input  logic [3:0]              octave_count,
    input  logic [3:0]              cell_shift,
    output logic                    out_valid,
    output logic [15:0]             out_x,
    output logic [15:0]             out_y,
    output logic signed [ACC_W-1:0] out_acc
);

    localparam int PW     = 16 + FRAC_BITS + OCT;
    localparam int QS     = ANGLE_TABLE_BITS - 2;
    localparam int QSIZE  = 1 << QS;
    localparam int LAT    = 11;
    localparam int SH     = MAX_OCTAVES - 1 - OCT;
    localparam int DW     = FRAC_BITS + 2;
    localparam int PROD_W = FRAC_BITS + 18;
    localparam int MT_W   = DOT_W + 18;
    localparam int MY_W   = NOISE_W + 18;
    localparam logic [DW-1:0] ONE_F = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic signed [23:0] FADE_C15 = 24'sd983040;
    localparam logic signed [23:0] FADE_C10 = 24'sd655360;

    // gradient tables, first quarter
    logic [14:0] cos_tab [QSIZE];
    logic [14:0] sin_tab [QSIZE];

    for (genvar t = 0; t < QSIZE; t++)
    begin : g_tab
        localparam logic [14:0] COS_V = grad_q14(t, QS, 1'b0);
        localparam logic [14:0] SIN_V = grad_q14(t, QS, 1'b1);
        assign cos_tab[t] = COS_V;
        assign sin_tab[t] = SIN_V;
    end

    // delay line for the passed-through item
    logic                    dly_valid_reg [LAT];
    logic [15:0]             dly_x_reg     [LAT];
    logic [15:0]             dly_y_reg     [LAT];
    logic signed [ACC_W-1:0] dly_acc_reg   [LAT];

    logic [PW-1:0]         pos_x;
    logic [PW-1:0]         pos_y;
    logic [31:0]           x0_reg, x1_reg, y0_reg, y1_reg;
    logic [FRAC_BITS-1:0]  wx_reg [5];
    logic [FRAC_BITS-1:0]  wy_reg [5];
    logic [31:0]           a2_reg [2];
    logic [31:0]           y2_reg [2];
    logic [31:0]           a3_reg [2];
    logic [31:0]           b_reg  [2][2];
    logic [31:0]           c_reg  [2][2];
    logic signed [15:0]    gx_next [2][2];
    logic signed [15:0]    gy_next [2][2];
    logic signed [15:0]    gx_reg  [2][2];
    logic signed [15:0]    gy_reg  [2][2];
    logic signed [DW-1:0]  dx_next [2];
    logic signed [DW-1:0]  dy_next [2];
    logic signed [PROD_W-1:0] prx_reg [2][2];
    logic signed [PROD_W-1:0] pry_reg [2][2];
    logic signed [PROD_W:0]   dsum    [2][2];
    logic signed [DOT_W-1:0]  dot_reg [2][2];
    logic signed [DOT_W:0]    dif_t, dif_b;
    logic signed [MT_W-1:0]   mt_reg, mb_reg;
    logic signed [DOT_W-1:0]  d00_reg, d01_reg;
    logic signed [NOISE_W-1:0] top_reg, bot_reg, top10_reg, noise_reg;
    logic signed [NOISE_W:0]   dif_y;
    logic signed [MY_W-1:0]    my_reg;

    // fade: index 0 is x, 1 is y
    logic [15:0]        fq_reg [2][4];
    logic signed [23:0] fp_reg [2][5];
    logic signed [16:0] uf_reg [2][4];
    logic [QS-1:0]      r_idx  [2][2];
    quarter_t           quad   [2][2];
    logic [ANGLE_TABLE_BITS-1:0] k_idx [2][2];

    function automatic logic [15:0] wx_or_wy(input int d);
        return (d == 0) ? 16'((48'(wx_reg[0]) << 16) >> FRAC_BITS)
                        : 16'((48'(wy_reg[0]) << 16) >> FRAC_BITS);
    endfunction

    assign pos_x = {in_x, {(FRAC_BITS + OCT){1'b0}}} >> cell_shift;
    assign pos_y = {in_y, {(FRAC_BITS + OCT){1'b0}}} >> cell_shift;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                k_idx[i][j] = c_reg[i][j][31 -: ANGLE_TABLE_BITS];
                quad[i][j]  = quarter_t'(k_idx[i][j][ANGLE_TABLE_BITS-1 -: 2]);
                r_idx[i][j] = k_idx[i][j][QS-1:0];
                case (quad[i][j])
                    Q_ZERO:
                    begin
                        gx_next[i][j] = 16'(cos_tab[r_idx[i][j]]);
                        gy_next[i][j] = 16'(sin_tab[r_idx[i][j]]);
                    end
                    Q_ONE:
                    begin
                        gx_next[i][j] = -16'(sin_tab[r_idx[i][j]]);
                        gy_next[i][j] = 16'(cos_tab[r_idx[i][j]]);
                    end
                    Q_TWO:
                    begin
                        gx_next[i][j] = -16'(cos_tab[r_idx[i][j]]);
                        gy_next[i][j] = -16'(sin_tab[r_idx[i][j]]);
                    end
                    default:
                    begin
                        gx_next[i][j] = 16'(sin_tab[r_idx[i][j]]);
                        gy_next[i][j] = -16'(cos_tab[r_idx[i][j]]);
                    end
                endcase
            end
        end
        dx_next[0] = -$signed({2'b00, wx_reg[4]});
        dx_next[1] = $signed(ONE_F - {2'b00, wx_reg[4]});
        dy_next[0] = -$signed({2'b00, wy_reg[4]});
        dy_next[1] = $signed(ONE_F - {2'b00, wy_reg[4]});
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                dsum[i][j] = (PROD_W + 1)'(prx_reg[i][j]) + (PROD_W + 1)'(pry_reg[i][j]);
            end
        end
        dif_t = (DOT_W + 1)'(dot_reg[1][0]) - (DOT_W + 1)'(dot_reg[0][0]);
        dif_b = (DOT_W + 1)'(dot_reg[1][1]) - (DOT_W + 1)'(dot_reg[0][1]);
        dif_y = (NOISE_W + 1)'(bot_reg) - (NOISE_W + 1)'(top_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LAT; s++)
            begin
                dly_valid_reg[s] <= 1'b0;
            end
            out_valid <= 1'b0;
        end
        else
        begin
            dly_valid_reg[0] <= in_valid;
            for (int s = 1; s < LAT; s++)
            begin
                dly_valid_reg[s] <= dly_valid_reg[s-1];
            end
            out_valid <= dly_valid_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dly_x_reg[0]   <= in_x;
        dly_y_reg[0]   <= in_y;
        dly_acc_reg[0] <= in_acc;
        for (int s = 1; s < LAT; s++)
        begin
            dly_x_reg[s]   <= dly_x_reg[s-1];
            dly_y_reg[s]   <= dly_y_reg[s-1];
            dly_acc_reg[s] <= dly_acc_reg[s-1];
        end

        // lattice position
        x0_reg    <= 32'(pos_x[PW-1:FRAC_BITS]);
        x1_reg    <= 32'(pos_x[PW-1:FRAC_BITS]) + 32'd1;
        y0_reg    <= 32'(pos_y[PW-1:FRAC_BITS]);
        y1_reg    <= 32'(pos_y[PW-1:FRAC_BITS]) + 32'd1;
        wx_reg[0] <= pos_x[FRAC_BITS-1:0];
        wy_reg[0] <= pos_y[FRAC_BITS-1:0];
        for (int s = 1; s < 5; s++)
        begin
            wx_reg[s] <= wx_reg[s-1];
            wy_reg[s] <= wy_reg[s-1];
        end

        // hash
        a2_reg[0] <= x0_reg * HASH_MUL_A;
        a2_reg[1] <= x1_reg * HASH_MUL_A;
        y2_reg[0] <= y0_reg;
        y2_reg[1] <= y1_reg;
        for (int i = 0; i < 2; i++)
        begin
            a3_reg[i] <= a2_reg[i];
            for (int j = 0; j < 2; j++)
            begin
                b_reg[i][j]  <= (y2_reg[j] ^ rot16(a2_reg[i])) * HASH_MUL_B;
                c_reg[i][j]  <= (a3_reg[i] ^ rot16(b_reg[i][j])) * HASH_MUL_C;
                gx_reg[i][j] <= gx_next[i][j];
                gy_reg[i][j] <= gy_next[i][j];
                prx_reg[i][j] <= PROD_W'(gx_reg[i][j] * dx_next[i]);
                pry_reg[i][j] <= PROD_W'(gy_reg[i][j] * dy_next[j]);
                dot_reg[i][j] <= DOT_W'(dsum[i][j] >>> (FRAC_BITS - 2));
            end
        end

        // quintic fade
        fq_reg[0][0] <= 16'((48'(wx_reg[0]) << 16) >> FRAC_BITS);
        fq_reg[1][0] <= 16'((48'(wy_reg[0]) << 16) >> FRAC_BITS);
        for (int d = 0; d < 2; d++)
        begin
            fp_reg[d][0] <= 24'(6 * 24'(wx_or_wy(d))) - FADE_C15;
            for (int s = 1; s < 4; s++)
            begin
                fq_reg[d][s] <= fq_reg[d][s-1];
            end
            fp_reg[d][1] <= 24'((41'(fp_reg[d][0]) * $signed({25'd0, fq_reg[d][0]})) >>> 16)
                            + FADE_C10;
            for (int s = 2; s < 5; s++)
            begin
                fp_reg[d][s] <= 24'((41'(fp_reg[d][s-1]) * $signed({25'd0, fq_reg[d][s-1]}))
                                    >>> 16);
            end
            uf_reg[d][0] <= 17'(fp_reg[d][4]);
            for (int s = 1; s < 4; s++)
            begin
                uf_reg[d][s] <= uf_reg[d][s-1];
            end
        end

        // blend
        mt_reg    <= MT_W'(dif_t * uf_reg[0][0]);
        mb_reg    <= MT_W'(dif_b * uf_reg[0][0]);
        d00_reg   <= dot_reg[0][0];
        d01_reg   <= dot_reg[0][1];
        top_reg   <= NOISE_W'(d00_reg) + NOISE_W'(mt_reg >>> 16);
        bot_reg   <= NOISE_W'(d01_reg) + NOISE_W'(mb_reg >>> 16);
        my_reg    <= MY_W'(dif_y * uf_reg[1][2]);
        top10_reg <= top_reg;
        noise_reg <= top10_reg + NOISE_W'(my_reg >>> 16);

        out_x <= dly_x_reg[LAT-1];
        out_y <= dly_y_reg[LAT-1];
        if (5'(octave_count) > 5'(OCT))
        begin
            out_acc <= dly_acc_reg[LAT-1] + (ACC_W'(noise_reg) <<< SH);
        end
        else
        begin
            out_acc <= dly_acc_reg[LAT-1];
        end
    end

endmodule

`default_nettype wire

// File: sv/fgn_level_map.sv
// fgn_level_map: scales the octave sum by 6/5, clamps and maps it to an 8-bit level.
// Three register stages. Depends on fgn_pkg.
`default_nettype none

module fgn_level_map
    import fgn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8,
    localparam int ACC_W      = NOISE_W + MAX_OCTAVES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [ACC_W-1:0] in_acc,
    output logic                    done,
    output logic [7:0]              noise_level
);

    localparam int SUM_BITS = 15 + MAX_OCTAVES;
    localparam int SW       = ACC_W + 3;
    localparam int VW       = SUM_BITS + 4;
    localparam int MW       = SUM_BITS + 10;
    localparam logic signed [SW-1:0] FIVE_ONE = SW'(5) <<< SUM_BITS;

    logic                 v1_reg, v2_reg;
    logic signed [SW-1:0] scaled_reg;
    logic signed [SW-1:0] off_next;
    logic                 hi_reg, lo_reg;
    logic [MW-1:0]        prod_reg;

    assign off_next = scaled_reg + FIVE_ONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            done   <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            done   <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        scaled_reg <= (SW'(in_acc) <<< 2) + (SW'(in_acc) <<< 1);
        hi_reg     <= scaled_reg > FIVE_ONE;
        lo_reg     <= scaled_reg < -FIVE_ONE;
        prod_reg   <= MW'(off_next[VW-1:0]) * MW'(51);
        if (hi_reg)
        begin
            noise_level <= 8'd255;
        end
        else if (lo_reg)
        begin
            noise_level <= 8'd0;
        end
        else
        begin
            noise_level <= prod_reg[SUM_BITS+8:SUM_BITS+1];
        end
    end

endmodule

`default_nettype wire

// File: bench/fgn_pixel_checker.sv
// fgn_pixel_checker: watches the pixel, result and register channels of the noise block,
// predicts each noise level and compares it with the block's output.
// Depends on fgn_pkg for the hash constants and register indexes.
`timescale 1ns / 100ps

module fgn_pixel_checker
    import fgn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] pixel_x,
    input  logic [15:0] pixel_y,
    input  logic        done,
    input  logic [7:0]  noise_level,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    output int          fail_count,
    output int          pending_levels
);

    localparam int OCT_LIMIT  = 8;
    localparam int ANGLE_BITS = 10;
    localparam int FRAC       = 16;
    localparam int SUM_W      = 16 + OCT_LIMIT - 1;

    logic [3:0] octaves_q;
    logic [3:0] shift_q;
    logic [7:0] level_queue[$];

    function automatic longint to_q14(longint v);
        if (v < 0)
        begin
            v = 0;
        end
        if (v > (longint'(1) << 30))
        begin
            v = longint'(1) << 30;
        end
        return (v + (longint'(1) << 15)) >>> 16;
    endfunction

    function automatic void gradient(input logic [31:0] k, output longint gx,
                                     output longint gy);
        int unsigned qs;
        quarter_t    quarter;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] tc;
        logic [63:0] ts;
        longint      c;
        longint      s;
        longint      cq;
        longint      sq;
        qs      = ANGLE_BITS - 2;
        quarter = quarter_t'((k >> qs) & 32'd3);
        r       = 64'(k & ((32'd1 << qs) - 32'd1));
        t       = (r * 64'd1686629713) >> qs;
        t2      = (t * t) >> 30;
        tc      = 64'd1 << 30;
        ts      = t;
        c       = 0;
        s       = 0;
        for (int n = 0; n < 7; n++)
        begin
            if (n % 2 == 1)
            begin
                c = c - longint'(tc);
                s = s - longint'(ts);
            end
            else
            begin
                c = c + longint'(tc);
                s = s + longint'(ts);
            end
            tc = ((tc * t2) >> 30) / 64'((2 * n + 1) * (2 * n + 2));
            ts = ((ts * t2) >> 30) / 64'((2 * n + 2) * (2 * n + 3));
        end
        cq = to_q14(c);
        sq = to_q14(s);
        case (quarter)
            Q_ZERO:  begin gx = cq;  gy = sq;  end
            Q_ONE:   begin gx = -sq; gy = cq;  end
            Q_TWO:   begin gx = -cq; gy = -sq; end
            default: begin gx = sq;  gy = -cq; end
        endcase
    endfunction

    function automatic longint lattice_dot(logic [31:0] cx, logic [31:0] cy, longint dx,
                                           longint dy);
        logic [31:0] a;
        logic [31:0] b;
        longint      gx;
        longint      gy;
        a = cx * HASH_MUL_A;
        b = cy ^ {a[15:0], a[31:16]};
        b = b * HASH_MUL_B;
        a = a ^ {b[15:0], b[31:16]};
        a = a * HASH_MUL_C;
        gradient(a >> (32 - ANGLE_BITS), gx, gy);
        return (gx * dx + gy * dy) >>> (FRAC - 2);
    endfunction

    function automatic longint quintic(longint w);
        longint x;
        longint p;
        x = (w << 16) >>> FRAC;
        p = 6 * x - 15 * 65536;
        p = ((p * x) >>> 16) + 10 * 65536;
        p = (p * x) >>> 16;
        p = (p * x) >>> 16;
        p = (p * x) >>> 16;
        return p;
    endfunction

    function automatic longint mix(longint a, longint b, longint f);
        return a + (((b - a) * f) >>> 16);
    endfunction

    function automatic longint octave_value(logic [15:0] px, logic [15:0] py, int oct,
                                            int shift);
        logic [63:0] fx;
        logic [63:0] fy;
        logic [31:0] x0;
        logic [31:0] y0;
        longint      wx;
        longint      wy;
        longint      one;
        longint      ux;
        longint      uy;
        longint      top;
        longint      bot;
        fx  = (64'(px) << (FRAC + oct)) >> shift;
        fy  = (64'(py) << (FRAC + oct)) >> shift;
        x0  = fx[FRAC+31:FRAC];
        y0  = fy[FRAC+31:FRAC];
        wx  = longint'(fx[FRAC-1:0]);
        wy  = longint'(fy[FRAC-1:0]);
        one = longint'(1) << FRAC;
        ux  = quintic(wx);
        uy  = quintic(wy);
        top = mix(lattice_dot(x0, y0, -wx, -wy), lattice_dot(x0 + 1, y0, one - wx, -wy), ux);
        bot = mix(lattice_dot(x0, y0 + 1, -wx, one - wy),
                  lattice_dot(x0 + 1, y0 + 1, one - wx, one - wy), ux);
        return mix(top, bot, uy);
    endfunction

    function automatic logic [7:0] pixel_level(logic [15:0] px, logic [15:0] py,
                                               logic [3:0] octs, logic [3:0] shift);
        int     n;
        longint one;
        longint acc;
        longint scaled;
        n   = (octs > OCT_LIMIT) ? OCT_LIMIT : int'(octs);
        one = longint'(1) << SUM_W;
        acc = 0;
        for (int i = 0; i < n; i++)
        begin
            acc = acc + (octave_value(px, py, i, int'(shift)) << (OCT_LIMIT - 1 - i));
        end
        scaled = 6 * acc;
        if (scaled > 5 * one)
        begin
            return 8'd255;
        end
        if (scaled < -5 * one)
        begin
            return 8'd0;
        end
        return 8'(((scaled + 5 * one) * 255) / (10 * one));
    endfunction

    assign pending_levels = level_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octaves_q  <= 4'd4;
            shift_q    <= 4'd6;
            fail_count <= 0;
            level_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_OCTAVE_COUNT)
                begin
                    octaves_q <= cfg_data;
                end
                else if (cfg_index == REG_CELL_SHIFT)
                begin
                    shift_q <= cfg_data;
                end
            end
            if (start && !busy)
            begin
                level_queue.push_back(pixel_level(pixel_x, pixel_y, octaves_q, shift_q));
            end
            if (done)
            begin
                if (level_queue.size() == 0)
                begin
                    $display("%0t: unexpected noise_level %0d", $time, noise_level);
                    fail_count <= fail_count + 1;
                end
                else if (level_queue[0] !== noise_level)
                begin
                    $display("%0t: noise_level expected %0d actual %0d", $time,
                             level_queue[0], noise_level);
                    fail_count <= fail_count + 1;
                    void'(level_queue.pop_front());
                end
                else
                begin
                    void'(level_queue.pop_front());
                end
            end
        end
    end

endmodule

// File: bench/fractal_gradient_noise_pixel_tb.sv
// fractal_gradient_noise_pixel_tb: drives pixels and register writes into the noise block
// under random gaps and several register settings; fgn_pixel_checker judges the results.
// Depends on fgn_pkg, fractal_gradient_noise_pixel and fgn_pixel_checker.
`timescale 1ns / 100ps

module fractal_gradient_noise_pixel_tb;
    import fgn_pkg::*;

    localparam int PIPE_CYCLES = 12 * 8 + 3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic        done;
    logic [7:0]  noise_level;
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_data;
    int          fail_count;
    int          pending_levels;

    fractal_gradient_noise_pixel i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .done        (done),
        .noise_level (noise_level),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    fgn_pixel_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .done           (done),
        .noise_level    (noise_level),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_levels (pending_levels)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic send_pixel(logic [15:0] x, logic [15:0] y);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_levels != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_CYCLES + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 255));
            1:       return 16'hFFFF - 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        #50ms;
        $display("fractal_gradient_noise_pixel_tb: FAIL");
        $finish;
    end

    initial
    begin
        logic [3:0] oct_set[8];
        logic [3:0] shift_set[8];
        oct_set   = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd9, 4'd2, 4'd3, 4'd4};
        shift_set = '{4'd0, 4'd12, 4'd15, 4'd13, 4'd0, 4'd6, 4'd1, 4'd14};
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel_x   = '0;
        pixel_y   = '0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, coordinate extremes
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000);
        send_pixel(16'h5555, 16'hAAAA);
        send_pixel(16'h0001, 16'h003F);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_OCTAVE_COUNT, oct_set[p]);
            write_reg(REG_CELL_SHIFT, shift_set[p]);
            send_pixel(16'h0000, 16'h0000);
            send_pixel(16'hFFFF, 16'hFFFF);
            send_pixel(16'hAAAA, 16'h5555);
            drain();
        end

        for (int p = 0; p < 12; p++)
        begin
            write_reg(REG_OCTAVE_COUNT, (p < 8) ? 4'($urandom_range(1, 8))
                                                : 4'($urandom_range(0, 15)));
            write_reg(REG_CELL_SHIFT, 4'($urandom_range(0, 15)));
            for (int i = 0; i < 155; i++)
            begin
                send_pixel(rand_coord(), rand_coord());
            end
            drain();
        end

        if (fail_count == 0)
        begin
            $display("fractal_gradient_noise_pixel_tb: PASS");
        end
        else
        begin
            $display("fractal_gradient_noise_pixel_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/fgn_pkg.sv
sv/fgn_octave_cell.sv
sv/fgn_level_map.sv
sv/fractal_gradient_noise_pixel.sv
bench/fgn_pixel_checker.sv
bench/fractal_gradient_noise_pixel_tb.sv
